[rtl/core/ata_pkg.sv]
// shared constants, a type and a function for the accelerometer tilt angle block
// no dependencies
package ata_pkg;

  localparam int XYZ_W = 16;
  localparam int TDATA_W = 48;
  localparam int SQ_IN_W = 50;
  localparam int ROOT_W = SQ_IN_W / 2;
  localparam int REM_W = ROOT_W + 1;
  localparam int SIDE_W = 48;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_RUN = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ANGLE_FRACTION_BITS = 8;
  localparam int ACC_FRAC = 16;
  localparam int RND_S = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam int CX_W = 28;
  localparam int CZ_W = 25;
  localparam int ANG_W = 16;
  localparam int TILT_W = 15;
  localparam int TILT_MAX = 32767;
  localparam logic signed [ANG_W-1:0] ANGLE_90 = ANG_W'(90 * (2 ** ANGLE_FRACTION_BITS));

  localparam logic signed [CZ_W-1:0] ATAN_DEG_Q16 [0:TABLE_LEN-1] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379, 25'sd117304,
    25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
    25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29,
    25'sd14, 25'sd7, 25'sd4, 25'sd2, 25'sd1, 25'sd0
  };

  typedef struct packed {
    logic zero_v;
    logic zero_x;
    logic neg_v;
  } lane_flags_t;

  // round to ANGLE_FRACTION_BITS, halves away from zero
  function automatic logic signed [ANG_W-1:0] round_angle(input logic signed [CZ_W-1:0] z);
    logic [CZ_W:0] mag;
    logic [CZ_W:0] r;
    begin
      mag = z[CZ_W-1] ? (CZ_W+1)'(-$signed({z[CZ_W-1], z})) : {1'b0, z};
      r = (mag + (CZ_W+1)'(2 ** (RND_S - 1))) >> RND_S;
      round_angle = z[CZ_W-1] ? ANG_W'(-$signed(r)) : ANG_W'(r);
    end
  endfunction

endpackage

[rtl/core/ata_sqrt.sv]
// pipelined integer square root, one root bit per register stage
// depends on ata_pkg
module ata_sqrt
  import ata_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  logic [SQ_IN_W-1:0] radicand,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               valid_out,
  output logic [ROOT_W-1:0]  root,
  output logic [REM_W-1:0]   remainder,
  output logic [SIDE_W-1:0]  side_out
);

  logic [SQ_IN_W-1:0] rad_q  [0:ROOT_W-1];
  logic [REM_W-1:0]   rem_q  [0:ROOT_W-1];
  logic [ROOT_W-1:0]  root_q [0:ROOT_W-1];
  logic [SIDE_W-1:0]  side_q [0:ROOT_W-1];
  logic               valid_q[0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [SQ_IN_W-1:0] rad_p;
    logic [REM_W-1:0]   rem_p;
    logic [ROOT_W-1:0]  root_p;
    logic [SIDE_W-1:0]  side_p;
    logic               valid_p;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign rad_p = radicand;
      assign rem_p = '0;
      assign root_p = '0;
      assign side_p = side_in;
      assign valid_p = valid_in;
    end else begin : g_rest
      assign rad_p = rad_q[k-1];
      assign rem_p = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
      assign valid_p = valid_q[k-1];
    end

    assign rem_sh = {rem_p, rad_p[SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= valid_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k] <= rad_p << 2;
        side_q[k] <= side_p;
        if (ge) begin
          rem_q[k] <= REM_W'(rem_sh - trial);
          root_q[k] <= {root_p[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= REM_W'(rem_sh);
          root_q[k] <= {root_p[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_out = valid_q[ROOT_W-1];
  assign root = root_q[ROOT_W-1];
  assign remainder = rem_q[ROOT_W-1];
  assign side_out = side_q[ROOT_W-1];

endmodule

[rtl/core/ata_cordic.sv]
// two-lane pipelined cordic vectoring, one rotation per stage, then angle rounding
// depends on ata_pkg
module ata_cordic
  import ata_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic [ROOT_W-1:0]       mag_p,
  input  logic signed [XYZ_W-1:0] vert_p,
  input  logic [ROOT_W-1:0]       mag_r,
  input  logic signed [XYZ_W-1:0] vert_r,
  output logic                    valid_out,
  output logic signed [ANG_W-1:0] pitch,
  output logic signed [ANG_W-1:0] roll
);

  logic signed [CX_W-1:0] x_q [0:CORDIC_RUN-1][0:1];
  logic signed [CX_W-1:0] y_q [0:CORDIC_RUN-1][0:1];
  logic signed [CZ_W-1:0] z_q [0:CORDIC_RUN-1][0:1];
  lane_flags_t            f_q [0:CORDIC_RUN-1][0:1];
  logic                   valid_q[0:CORDIC_RUN-1];

  logic [ROOT_W-1:0]       mag_in [0:1];
  logic signed [XYZ_W-1:0] vert_in[0:1];

  assign mag_in[0] = mag_p;
  assign mag_in[1] = mag_r;
  assign vert_in[0] = vert_p;
  assign vert_in[1] = vert_r;

  for (genvar k = 0; k < CORDIC_RUN; k++) begin : g_stage
    logic valid_p;

    if (k == 0) begin : g_vfirst
      assign valid_p = valid_in;
    end else begin : g_vrest
      assign valid_p = valid_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= valid_p;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [CX_W-1:0] x_p;
      logic signed [CX_W-1:0] y_p;
      logic signed [CZ_W-1:0] z_p;
      lane_flags_t            f_p;
      logic signed [CX_W-1:0] xs;
      logic signed [CX_W-1:0] ys;

      if (k == 0) begin : g_first
        assign x_p = $signed({{(CX_W-ROOT_W){1'b0}}, mag_in[l]});
        assign y_p = $signed({{(CX_W-XYZ_W-8){vert_in[l][XYZ_W-1]}}, vert_in[l], 8'b0});
        assign z_p = '0;
        assign f_p.zero_v = (vert_in[l] == '0);
        assign f_p.zero_x = (mag_in[l] == '0);
        assign f_p.neg_v = vert_in[l][XYZ_W-1];
      end else begin : g_rest
        assign x_p = x_q[k-1][l];
        assign y_p = y_q[k-1][l];
        assign z_p = z_q[k-1][l];
        assign f_p = f_q[k-1][l];
      end

      assign xs = x_p >>> k;
      assign ys = y_p >>> k;

      always_ff @(posedge clk) begin
        if (en) begin
          f_q[k][l] <= f_p;
          if (y_p > 0) begin
            x_q[k][l] <= x_p + ys;
            y_q[k][l] <= y_p - xs;
            z_q[k][l] <= z_p + ATAN_DEG_Q16[k];
          end else begin
            x_q[k][l] <= x_p - ys;
            y_q[k][l] <= y_p + xs;
            z_q[k][l] <= z_p - ATAN_DEG_Q16[k];
          end
        end
      end
    end
  end

  logic signed [ANG_W-1:0] ang_next[0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (f_q[CORDIC_RUN-1][l].zero_v) begin
        ang_next[l] = '0;
      end else if (f_q[CORDIC_RUN-1][l].zero_x) begin
        ang_next[l] = f_q[CORDIC_RUN-1][l].neg_v ? -ANGLE_90 : ANGLE_90;
      end else begin
        ang_next[l] = round_angle(z_q[CORDIC_RUN-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_q[CORDIC_RUN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch <= ang_next[0];
      roll <= ang_next[1];
    end
  end

endmodule

[rtl/core/ata_tilt.sv]
// combined tilt: squares of both angles, sum, root, round to nearest and saturate
// depends on ata_pkg and ata_sqrt
module ata_tilt
  import ata_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic signed [ANG_W-1:0] pitch_in,
  input  logic signed [ANG_W-1:0] roll_in,
  output logic                    valid_out,
  output logic signed [ANG_W-1:0] pitch,
  output logic signed [ANG_W-1:0] roll,
  output logic [TILT_W-1:0]       tilt
);

  logic                    v1;
  logic                    v2;
  logic signed [ANG_W-1:0] p1;
  logic signed [ANG_W-1:0] r1;
  logic signed [ANG_W-1:0] p2;
  logic signed [ANG_W-1:0] r2;
  logic [2*ANG_W-2:0]      pp;
  logic [2*ANG_W-2:0]      rr;
  logic [2*ANG_W-1:0]      sum;
  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_root;
  logic [REM_W-1:0]        sq_rem;
  logic [SIDE_W-1:0]       sq_side;
  logic [ROOT_W:0]         t_round;
  logic [TILT_W-1:0]       tilt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= pitch_in;
      r1 <= roll_in;
      pp <= (2*ANG_W-1)'(pitch_in * pitch_in);
      rr <= (2*ANG_W-1)'(roll_in * roll_in);
      p2 <= p1;
      r2 <= r1;
      sum <= {1'b0, pp} + {1'b0, rr};
    end
  end

  ata_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v2),
    .radicand  ({{(SQ_IN_W-2*ANG_W){1'b0}}, sum}),
    .side_in   ({{(SIDE_W-2*ANG_W){1'b0}}, r2, p2}),
    .valid_out (sq_valid),
    .root      (sq_root),
    .remainder (sq_rem),
    .side_out  (sq_side)
  );

  always_comb begin
    t_round = {1'b0, sq_root} + ((sq_rem > {1'b0, sq_root}) ? (ROOT_W+1)'(1) : '0);
    tilt_next = (t_round > (ROOT_W+1)'(TILT_MAX)) ? TILT_W'(TILT_MAX) : t_round[TILT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch <= sq_side[ANG_W-1:0];
      roll <= sq_side[2*ANG_W-1:ANG_W];
      tilt <= tilt_next;
    end
  end

endmodule

[rtl/core/accel_tilt_angle.sv]
// accelerometer pitch, roll and tilt: top level with squares, root, cordic and tilt stages
// depends on ata_pkg, ata_sqrt, ata_cordic and ata_tilt
// throughput one word per cycle while the pipeline advances
// the whole pipeline advances when the output register is empty or being taken
// synchronous reset clears all valid bits; data registers are not reset
module accel_tilt_angle
  import ata_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,  // accel_x, accel_y, accel_z
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata   // pitch_deg, roll_deg, tilt_deg, zero pad
);

  logic                    en;
  logic                    v0;
  logic                    v1;
  logic signed [XYZ_W-1:0] ax0;
  logic signed [XYZ_W-1:0] ay0;
  logic signed [XYZ_W-1:0] az0;
  logic signed [XYZ_W-1:0] ax1;
  logic signed [XYZ_W-1:0] ay1;
  logic signed [XYZ_W-1:0] az1;
  logic [2*XYZ_W-2:0]      xx;
  logic [2*XYZ_W-2:0]      yy;
  logic [2*XYZ_W-2:0]      zz;
  logic [2*XYZ_W-1:0]      sum_p;
  logic [2*XYZ_W-1:0]      sum_r;
  logic                    sp_valid;
  logic [ROOT_W-1:0]       root_p;
  logic [ROOT_W-1:0]       root_r;
  logic [SIDE_W-1:0]       side_p;
  logic                    cd_valid;
  logic signed [ANG_W-1:0] cd_pitch;
  logic signed [ANG_W-1:0] cd_roll;
  logic signed [ANG_W-1:0] o_pitch;
  logic signed [ANG_W-1:0] o_roll;
  logic [TILT_W-1:0]       o_tilt;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= s_tdata[XYZ_W-1:0];
      ay0 <= s_tdata[2*XYZ_W-1:XYZ_W];
      az0 <= s_tdata[3*XYZ_W-1:2*XYZ_W];
      xx <= (2*XYZ_W-1)'($signed(s_tdata[XYZ_W-1:0]) * $signed(s_tdata[XYZ_W-1:0]));
      yy <= (2*XYZ_W-1)'($signed(s_tdata[2*XYZ_W-1:XYZ_W])
                         * $signed(s_tdata[2*XYZ_W-1:XYZ_W]));
      zz <= (2*XYZ_W-1)'($signed(s_tdata[3*XYZ_W-1:2*XYZ_W])
                         * $signed(s_tdata[3*XYZ_W-1:2*XYZ_W]));
      ax1 <= ax0;
      ay1 <= ay0;
      az1 <= az0;
      sum_p <= {1'b0, xx} + {1'b0, zz};
      sum_r <= {1'b0, yy} + {1'b0, zz};
    end
  end

  ata_sqrt u_sqrt_p (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v1),
    .radicand  ({{(SQ_IN_W-2*XYZ_W-16){1'b0}}, sum_p, 16'b0}),
    .side_in   ({az1, ay1, ax1}),
    .valid_out (sp_valid),
    .root      (root_p),
    .remainder (),
    .side_out  (side_p)
  );

  ata_sqrt u_sqrt_r (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v1),
    .radicand  ({{(SQ_IN_W-2*XYZ_W-16){1'b0}}, sum_r, 16'b0}),
    .side_in   ({az1, ay1, ax1}),
    .valid_out (),
    .root      (root_r),
    .remainder (),
    .side_out  ()
  );

  ata_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (sp_valid),
    .mag_p     (root_p),
    .vert_p    (side_p[2*XYZ_W-1:XYZ_W]),
    .mag_r     (root_r),
    .vert_r    (side_p[XYZ_W-1:0]),
    .valid_out (cd_valid),
    .pitch     (cd_pitch),
    .roll      (cd_roll)
  );

  ata_tilt u_tilt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (cd_valid),
    .pitch_in  (cd_pitch),
    .roll_in   (cd_roll),
    .valid_out (m_tvalid),
    .pitch     (o_pitch),
    .roll      (o_roll),
    .tilt      (o_tilt)
  );

  assign m_tdata = {{(TDATA_W-2*ANG_W-TILT_W){1'b0}}, o_tilt, o_roll, o_pitch};

endmodule

[dv/tilt_checker.sv]
// checker for the accelerometer tilt angle block: watches both stream channels,
// predicts pitch, roll and tilt for each accepted sample and compares them
// depends on ata_pkg
module tilt_checker
  import ata_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  output int                 n_fail,
  output int                 n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] roll;
    logic [TILT_W-1:0]       tilt;
  } angles_t;

  localparam longint ATAN_TBL [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  angles_t angles_q[$];

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint rounded_deg(longint z);
    longint h, r;
    h = 64'sd1 << (RND_S - 1);
    if (z >= 0) r = (z + h) >>> RND_S;
    else r = -((-z + h) >>> RND_S);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint axis_angle(longint v, longint a, longint b);
    longint x, y, z, xs, ys;
    longint unsigned s;
    s = a * a + b * b;
    x = int_root(s << 16);
    y = v * 256;
    z = 0;
    if (v == 0) return 0;
    if (x == 0) return rounded_deg(v > 0 ? (64'sd90 <<< ACC_FRAC) : -(64'sd90 <<< ACC_FRAC));
    for (int i = 0; i < CORDIC_RUN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += ATAN_TBL[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_TBL[i];
      end
    end
    return rounded_deg(z);
  endfunction

  function automatic angles_t predict_angles(logic [TDATA_W-1:0] d);
    longint ax, ay, az, p, r;
    longint unsigned sq, t;
    angles_t e;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    p = axis_angle(ay, ax, az);
    r = axis_angle(ax, ay, az);
    sq = p * p + r * r;
    t = int_root(sq);
    if (sq - t * t > t) t++;
    if (t > TILT_MAX) t = TILT_MAX;
    e.pitch = p[15:0];
    e.roll = r[15:0];
    e.tilt = t[14:0];
    return e;
  endfunction

  assign n_pending = angles_q.size();

  always @(posedge clk) begin
    angles_t e, got;
    if (rst) begin
      n_fail <= 0;
      angles_q.delete();
    end else begin
      if (s_tvalid && s_tready) angles_q.push_back(predict_angles(s_tdata));
      if (m_tvalid && m_tready) begin
        got.pitch = m_tdata[15:0];
        got.roll = m_tdata[31:16];
        got.tilt = m_tdata[46:32];
        if (angles_q.size() == 0) begin
          if (n_fail < 10) $display("unexpected word %h", m_tdata);
          n_fail <= n_fail + 1;
        end else begin
          e = angles_q.pop_front();
          if (e != got) begin
            if (n_fail < 10)
              $display("mismatch pitch %0d/%0d roll %0d/%0d tilt %0d/%0d (exp/got)",
                       e.pitch, got.pitch, e.roll, got.roll, e.tilt, got.tilt);
            n_fail <= n_fail + 1;
          end
        end
      end
    end
  end
endmodule

[dv/tb.sv]
// stimulus and verdict for the accelerometer tilt angle block
// depends on ata_pkg, accel_tilt_angle and tilt_checker
module tb;
  import ata_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [TDATA_W-1:0] s_tdata, m_tdata;
  int n_fail, n_pending, idle_cycles;
  bit hold_long;

  accel_tilt_angle dut (.*);
  tilt_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    s_tdata <= {z, y, x};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // receiver: stall pattern plus one long hold-off
  initial begin
    bit long_done;
    long_done = 0;
    m_tready = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_long && !long_done) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        long_done = 1;
      end
      case ($urandom_range(0, 3))
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 3) != 0;
        default: m_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  initial begin
    logic [15:0] dir [0:5];
    dir = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h4000};
    hold_long = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_sample(16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 20; i++) send_sample(dir[i % 6], dir[(i / 6) % 6], dir[(i * 5) % 6]);
    hold_long = 1;
    for (int i = 0; i < 2000; i++) begin
      if (i == 1000) begin
        s_tvalid <= 0;
        wait (n_pending == 0);
        @(negedge clk);
      end
      if ($urandom_range(0, 7) == 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      send_sample(rand_axis(), rand_axis(), rand_axis());
    end
    s_tvalid <= 0;
    wait (n_pending == 0);
    repeat (100) @(posedge clk);
    if (n_fail == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else if (idle_cycles >= 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end
endmodule

[filelist.f]
rtl/core/ata_pkg.sv
rtl/core/ata_sqrt.sv
rtl/core/ata_cordic.sv
rtl/core/ata_tilt.sv
rtl/core/accel_tilt_angle.sv
dv/tilt_checker.sv
dv/tb.sv
